// File: sv/csh_pkg.sv
// Shared widths, latencies and types for the capsule segment hit test pipeline.
package csh_pkg;

	// Field widths
	localparam int COORD_W = 24;            // Q16.8 coordinate
	localparam int RAD_W   = 16;            // Q8.8 radius
	localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
	localparam int PRD_W   = 2 * DIFF_W;    // product of two differences
	localparam int DOT_W   = PRD_W + 1;     // sum of two products
	localparam int WIDE_W  = 2 * DOT_W;     // det, s and t numerators
	localparam int QF_W    = 16;            // fraction bits of s and t
	localparam int Q_W     = QF_W + 1;      // s and t including the value one
	localparam int PQ_W    = Q_W + 1 + DIFF_W; // s or t times a difference
	localparam int OFS_W   = PQ_W + 1;      // closest point offset, Q.24
	localparam int SQ_W    = 2 * OFS_W;     // squared offset, Q.48
	localparam int THR_W   = 2 * (RAD_W + 1); // squared radius sum, Q.16
	localparam int DROP_W  = 32;            // Q.48 down to Q.16
	localparam int DIST_W  = 52;            // reported squared distance

	localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << QF_W;

	// Latencies in register stages
	localparam int MUL_LAT   = 3;
	localparam int FRONT_LAT = 5 + MUL_LAT;
	localparam int DIV_LAT   = QF_W + 1;
	localparam int DIST_LAT  = 3 + MUL_LAT;
	localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + DIST_LAT;

	// Segment geometry carried down the pipe
	typedef struct packed {
		logic signed [DIFF_W-1:0] ex;
		logic signed [DIFF_W-1:0] ey;
		logic signed [DIFF_W-1:0] fx;
		logic signed [DIFF_W-1:0] fy;
		logic signed [DIFF_W-1:0] gx;
		logic signed [DIFF_W-1:0] gy;
		logic [RAD_W-1:0]         r1;
		logic [RAD_W-1:0]         r2;
	} geom_t;

endpackage

// File: sv/csh_mul.sv
// Three-stage signed multiplier built from four half-width partial products.
module csh_mul #(
	parameter int W = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int H  = (W + 1) / 2;
	localparam int PW = 2 * W;

	logic [W-1:0]    ma, mb;
	logic [H-1:0]    alo, ahi, blo, bhi;
	logic [2*H-1:0]  pll_s1, plh_s1, phl_s1, phh_s1;
	logic            neg_s1, neg_s2;
	logic [PW-1:0]   sum_s2;
	logic signed [PW-1:0] p_s3;

	// magnitudes and halves
	always_comb begin
		ma  = a[W-1] ? W'(-a) : W'(a);
		mb  = b[W-1] ? W'(-b) : W'(b);
		alo = ma[H-1:0];
		blo = mb[H-1:0];
		ahi = H'(ma[W-1:H]);
		bhi = H'(mb[W-1:H]);
	end

	// partial products, then their sum, then the sign
	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= (2*H)'(alo) * (2*H)'(blo);
			plh_s1 <= (2*H)'(alo) * (2*H)'(bhi);
			phl_s1 <= (2*H)'(ahi) * (2*H)'(blo);
			phh_s1 <= (2*H)'(ahi) * (2*H)'(bhi);
			neg_s1 <= a[W-1] ^ b[W-1];
			sum_s2 <= PW'(pll_s1) + ((PW'(plh_s1) + PW'(phl_s1)) << H)
				+ (PW'(phh_s1) << (2 * H));
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? PW'(-sum_s2) : PW'(sum_s2);
		end
	end

	assign p = p_s3;

endmodule

// File: sv/csh_front.sv
// Front end: segment differences, dot products, determinant and divider setup.
module csh_front import csh_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] p1x,
	input  logic signed [COORD_W-1:0] p1y,
	input  logic signed [COORD_W-1:0] p2x,
	input  logic signed [COORD_W-1:0] p2y,
	input  logic signed [COORD_W-1:0] q1x,
	input  logic signed [COORD_W-1:0] q1y,
	input  logic signed [COORD_W-1:0] q2x,
	input  logic signed [COORD_W-1:0] q2y,
	input  logic [RAD_W-1:0]          r1,
	input  logic [RAD_W-1:0]          r2,
	output geom_t                     geom,
	output logic signed [WIDE_W-1:0]  num_s,
	output logic signed [WIDE_W-1:0]  den_s,
	output logic signed [WIDE_W-1:0]  num_t,
	output logic signed [WIDE_W-1:0]  den_t
);

	typedef struct packed {
		logic signed [PRD_W-1:0] exex, eyey, fxfx, fyfy, exfx;
		logic signed [PRD_W-1:0] eyfy, exgx, eygy, fxgx, fygy;
	} prod_t;

	typedef struct packed {
		logic signed [DOT_W-1:0] a, b, c, d, ee;
	} dot_t;

	function automatic logic signed [PRD_W-1:0] mul_dd(
		input logic signed [DIFF_W-1:0] x,
		input logic signed [DIFF_W-1:0] y
	);
		return PRD_W'(x) * PRD_W'(y);
	endfunction

	geom_t geom_s1, geom_s2, geom_s3, geom_s4, geom_s5, geom_s6, geom_s7, geom_s8;
	prod_t prod_s2;
	dot_t  dot_s3, dot_s4, dot_s5, dot_s6, dot_s7;
	logic signed [WIDE_W-1:0] ac, bb, be, cd, ae, bd;
	logic signed [WIDE_W-1:0] det_s7, sn_s7, tn_s7;
	logic signed [WIDE_W-1:0] wa, wb, wc, wd, we;
	logic signed [WIDE_W-1:0] ns, ds, nt, dt;
	logic signed [WIDE_W-1:0] ns_s8, ds_s8, nt_s8, dt_s8;

	// stage 1: direction and offset vectors
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1.ex <= DIFF_W'(p2x) - DIFF_W'(p1x);
			geom_s1.ey <= DIFF_W'(p2y) - DIFF_W'(p1y);
			geom_s1.fx <= DIFF_W'(q2x) - DIFF_W'(q1x);
			geom_s1.fy <= DIFF_W'(q2y) - DIFF_W'(q1y);
			geom_s1.gx <= DIFF_W'(p1x) - DIFF_W'(q1x);
			geom_s1.gy <= DIFF_W'(p1y) - DIFF_W'(q1y);
			geom_s1.r1 <= r1;
			geom_s1.r2 <= r2;
		end
	end

	// stages 2 and 3: products, then dot products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.exex <= mul_dd(geom_s1.ex, geom_s1.ex);
			prod_s2.eyey <= mul_dd(geom_s1.ey, geom_s1.ey);
			prod_s2.fxfx <= mul_dd(geom_s1.fx, geom_s1.fx);
			prod_s2.fyfy <= mul_dd(geom_s1.fy, geom_s1.fy);
			prod_s2.exfx <= mul_dd(geom_s1.ex, geom_s1.fx);
			prod_s2.eyfy <= mul_dd(geom_s1.ey, geom_s1.fy);
			prod_s2.exgx <= mul_dd(geom_s1.ex, geom_s1.gx);
			prod_s2.eygy <= mul_dd(geom_s1.ey, geom_s1.gy);
			prod_s2.fxgx <= mul_dd(geom_s1.fx, geom_s1.gx);
			prod_s2.fygy <= mul_dd(geom_s1.fy, geom_s1.gy);
			geom_s2      <= geom_s1;
			dot_s3.a  <= DOT_W'(prod_s2.exex) + DOT_W'(prod_s2.eyey);
			dot_s3.b  <= DOT_W'(prod_s2.exfx) + DOT_W'(prod_s2.eyfy);
			dot_s3.c  <= DOT_W'(prod_s2.fxfx) + DOT_W'(prod_s2.fyfy);
			dot_s3.d  <= DOT_W'(prod_s2.exgx) + DOT_W'(prod_s2.eygy);
			dot_s3.ee <= DOT_W'(prod_s2.fxgx) + DOT_W'(prod_s2.fygy);
			geom_s3   <= geom_s2;
		end
	end

	// stages 4 to 6: wide cross products
	csh_mul #(.W(DOT_W)) u_mul_ac (.clk, .en, .a(dot_s3.a), .b(dot_s3.c),  .p(ac));
	csh_mul #(.W(DOT_W)) u_mul_bb (.clk, .en, .a(dot_s3.b), .b(dot_s3.b),  .p(bb));
	csh_mul #(.W(DOT_W)) u_mul_be (.clk, .en, .a(dot_s3.b), .b(dot_s3.ee), .p(be));
	csh_mul #(.W(DOT_W)) u_mul_cd (.clk, .en, .a(dot_s3.c), .b(dot_s3.d),  .p(cd));
	csh_mul #(.W(DOT_W)) u_mul_ae (.clk, .en, .a(dot_s3.a), .b(dot_s3.ee), .p(ae));
	csh_mul #(.W(DOT_W)) u_mul_bd (.clk, .en, .a(dot_s3.b), .b(dot_s3.d),  .p(bd));

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s4  <= dot_s3;
			dot_s5  <= dot_s4;
			dot_s6  <= dot_s5;
			geom_s4 <= geom_s3;
			geom_s5 <= geom_s4;
			geom_s6 <= geom_s5;
		end
	end

	// stage 7: determinant and unclamped numerators
	always_ff @(posedge clk) begin
		if (en) begin
			det_s7  <= ac - bb;
			sn_s7   <= be - cd;
			tn_s7   <= ae - bd;
			dot_s7  <= dot_s6;
			geom_s7 <= geom_s6;
		end
	end

	// stage 8: pick the ratio for each parameter; a fixed value is 0/1 or 1/1
	always_comb begin
		wa = WIDE_W'(dot_s7.a);
		wb = WIDE_W'(dot_s7.b);
		wc = WIDE_W'(dot_s7.c);
		wd = WIDE_W'(dot_s7.d);
		we = WIDE_W'(dot_s7.ee);
		ns = '0;
		ds = WIDE_W'(1);
		nt = we;
		dt = wc;
		if (det_s7 == '0) begin
			if (dot_s7.b > dot_s7.c) begin
				nt = wd;
				dt = wb;
			end
		end else if (sn_s7 < 0) begin
			ns = '0;
		end else if (sn_s7 > det_s7) begin
			ns = WIDE_W'(1);
			nt = wb + we;
		end else if (tn_s7 < 0) begin
			ns = -wd;
			ds = wa;
			nt = '0;
			dt = WIDE_W'(1);
		end else if (tn_s7 > det_s7) begin
			ns = wb - wd;
			ds = wa;
			nt = WIDE_W'(1);
			dt = WIDE_W'(1);
		end else begin
			ns = sn_s7;
			ds = det_s7;
			nt = tn_s7;
			dt = det_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s8   <= ns;
			ds_s8   <= ds;
			nt_s8   <= nt;
			dt_s8   <= dt;
			geom_s8 <= geom_s7;
		end
	end

	assign geom  = geom_s8;
	assign num_s = ns_s8;
	assign den_s = ds_s8;
	assign num_t = nt_s8;
	assign den_t = dt_s8;

endmodule

// File: sv/csh_div.sv
// Pipelined clamped ratio: one quotient bit per stage, restoring division.
module csh_div import csh_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WIDE_W-1:0] num,
	input  logic signed [WIDE_W-1:0] den,
	output logic [Q_W-1:0]           q
);

	typedef struct packed {
		logic [WIDE_W-1:0] rem;
		logic [WIDE_W-1:0] dvs;
		logic [QF_W-1:0]   quo;
		logic              zero;
		logic              one;
	} dstage_t;

	dstage_t st_s [QF_W+1];

	// entry stage: trivial outcomes decided here
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].rem  <= num;
			st_s[0].dvs  <= den;
			st_s[0].quo  <= '0;
			st_s[0].zero <= (num <= 0) || (den <= 0);
			st_s[0].one  <= num >= den;
		end
	end

	// one restoring step per stage; remainder stays below the divisor
	for (genvar k = 0; k < QF_W; k++) begin : g_step
		logic [WIDE_W:0] rem2, diff;
		logic            ge;

		always_comb begin
			rem2 = {st_s[k].rem, 1'b0};
			diff = rem2 - {1'b0, st_s[k].dvs};
			ge   = rem2 >= {1'b0, st_s[k].dvs};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1].rem  <= ge ? diff[WIDE_W-1:0] : rem2[WIDE_W-1:0];
				st_s[k+1].dvs  <= st_s[k].dvs;
				st_s[k+1].quo  <= {st_s[k].quo[QF_W-2:0], ge};
				st_s[k+1].zero <= st_s[k].zero;
				st_s[k+1].one  <= st_s[k].one;
			end
		end
	end

	assign q = st_s[QF_W].zero ? '0 :
		(st_s[QF_W].one ? ONE_Q : {1'b0, st_s[QF_W].quo});

endmodule

// File: sv/csh_dist.sv
// Back end: closest point offset, squared distance, saturation and hit test.
module csh_dist import csh_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  geom_t             geom,
	input  logic [Q_W-1:0]    s,
	input  logic [Q_W-1:0]    t,
	output logic              hit,
	output logic [Q_W-1:0]    t_clamp,
	output logic [DIST_W-1:0] dist_squared
);

	function automatic logic signed [PQ_W-1:0] mul_qd(
		input logic [Q_W-1:0]           qv,
		input logic signed [DIFF_W-1:0] x
	);
		logic signed [Q_W:0] qs;
		qs = {1'b0, qv};
		return PQ_W'(qs) * PQ_W'(x);
	endfunction

	logic signed [PQ_W-1:0]  sex_s1, sey_s1, tfx_s1, tfy_s1;
	logic signed [DIFF_W-1:0] gx_s1, gy_s1;
	logic [RAD_W-1:0]        r1_s1, r2_s1;
	logic [Q_W-1:0]          t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	logic signed [OFS_W-1:0] rx_s2, ry_s2;
	logic [RAD_W:0]          rsum;
	logic [THR_W-1:0]        thr_c, thr_s2, thr_s3, thr_s4, thr_s5;
	logic                    r2nz_s2, r2nz_s3, r2nz_s4, r2nz_s5;
	logic signed [SQ_W-1:0]  rxx, ryy;
	logic [SQ_W-1:0]         dsum;
	logic [SQ_W-1:0]         thr_w;
	logic                    hit_s6;
	logic [DIST_W-1:0]       dq_s6;

	// stage 1: parameter times direction
	always_ff @(posedge clk) begin
		if (en) begin
			sex_s1 <= mul_qd(s, geom.ex);
			sey_s1 <= mul_qd(s, geom.ey);
			tfx_s1 <= mul_qd(t, geom.fx);
			tfy_s1 <= mul_qd(t, geom.fy);
			gx_s1  <= geom.gx;
			gy_s1  <= geom.gy;
			r1_s1  <= geom.r1;
			r2_s1  <= geom.r2;
			t_s1   <= t;
		end
	end

	// stage 2: offset between the closest points, squared radius sum
	always_comb begin
		rsum  = (RAD_W+1)'(r1_s1) + (RAD_W+1)'(r2_s1);
		thr_c = THR_W'(rsum) * THR_W'(rsum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s2   <= (OFS_W'(gx_s1) <<< QF_W) + OFS_W'(sex_s1) - OFS_W'(tfx_s1);
			ry_s2   <= (OFS_W'(gy_s1) <<< QF_W) + OFS_W'(sey_s1) - OFS_W'(tfy_s1);
			thr_s2  <= thr_c;
			r2nz_s2 <= r2_s1 != '0;
			t_s2    <= t_s1;
		end
	end

	// stages 3 to 5: squares of the offset
	csh_mul #(.W(OFS_W)) u_mul_xx (.clk, .en, .a(rx_s2), .b(rx_s2), .p(rxx));
	csh_mul #(.W(OFS_W)) u_mul_yy (.clk, .en, .a(ry_s2), .b(ry_s2), .p(ryy));

	always_ff @(posedge clk) begin
		if (en) begin
			thr_s3  <= thr_s2;
			thr_s4  <= thr_s3;
			thr_s5  <= thr_s4;
			r2nz_s3 <= r2nz_s2;
			r2nz_s4 <= r2nz_s3;
			r2nz_s5 <= r2nz_s4;
			t_s3    <= t_s2;
			t_s4    <= t_s3;
			t_s5    <= t_s4;
		end
	end

	// stage 6: distance, compare in Q.48, saturate the Q.16 report
	always_comb begin
		dsum  = SQ_W'(rxx) + SQ_W'(ryy);
		thr_w = SQ_W'({thr_s5, {DROP_W{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6 <= r2nz_s5 && (dsum < thr_w);
			dq_s6  <= (|dsum[SQ_W-1:DIST_W+DROP_W]) ? '1 : dsum[DIST_W+DROP_W-1:DROP_W];
			t_s6   <= t_s5;
		end
	end

	assign hit          = hit_s6;
	assign t_clamp      = t_s6;
	assign dist_squared = dq_s6;

endmodule

// File: sv/capsule_segment_hit_test.sv
// Capsule against capsule overlap test in 2-D, fully pipelined.
// Takes one segment pair with radii per cycle and returns hit, the clamped
// parameter t along segment two (Q1.16) and the squared closest distance
// (Q.16, saturating) at the end of the pipe, the beat landing
// in the first of 31 register stages: eight stages of differences, dot
// products, a three-stage 51x51 cross product multiplier and case selection,
// seventeen stages for the two parallel bit-per-stage dividers that produce s
// and t, and six stages for the offset, its squares and the final compare.
// The whole pipe advances together; it holds only while a result is waiting
// and out_ready is low.
module capsule_segment_hit_test import csh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] seg1_start_x,
	input  logic signed [COORD_W-1:0] seg1_start_y,
	input  logic signed [COORD_W-1:0] seg1_end_x,
	input  logic signed [COORD_W-1:0] seg1_end_y,
	input  logic signed [COORD_W-1:0] seg2_start_x,
	input  logic signed [COORD_W-1:0] seg2_start_y,
	input  logic signed [COORD_W-1:0] seg2_end_x,
	input  logic signed [COORD_W-1:0] seg2_end_y,
	input  logic [RAD_W-1:0]          radius_one,
	input  logic [RAD_W-1:0]          radius_two,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic [Q_W-1:0]            t_clamp,
	output logic [DIST_W-1:0]         dist_squared
);

	logic                     en;
	logic [TOTAL_LAT-1:0]     valid_s;
	geom_t                    geom_f;
	geom_t                    geom_dly_s [DIV_LAT];
	logic signed [WIDE_W-1:0] num_s, den_s, num_t, den_t;
	logic [Q_W-1:0]           s_q16, t_q16;

	// pipe advances unless a finished beat is waiting and out_ready is low
	assign en       = !valid_s[TOTAL_LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = valid_s[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[TOTAL_LAT-2:0], in_valid};
		end
	end

	csh_front u_front (
		.clk, .en,
		.p1x(seg1_start_x), .p1y(seg1_start_y),
		.p2x(seg1_end_x),   .p2y(seg1_end_y),
		.q1x(seg2_start_x), .q1y(seg2_start_y),
		.q2x(seg2_end_x),   .q2y(seg2_end_y),
		.r1(radius_one),    .r2(radius_two),
		.geom(geom_f),
		.num_s, .den_s, .num_t, .den_t
	);

	csh_div u_div_s (.clk, .en, .num(num_s), .den(den_s), .q(s_q16));
	csh_div u_div_t (.clk, .en, .num(num_t), .den(den_t), .q(t_q16));

	// geometry waits out the divider
	always_ff @(posedge clk) begin
		if (en) begin
			geom_dly_s[0] <= geom_f;
			for (int i = 1; i < DIV_LAT; i++) begin
				geom_dly_s[i] <= geom_dly_s[i-1];
			end
		end
	end

	csh_dist u_dist (
		.clk, .en,
		.geom(geom_dly_s[DIV_LAT-1]),
		.s(s_q16), .t(t_q16),
		.hit, .t_clamp, .dist_squared
	);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the capsule segment hit test pipeline.
`timescale 1ns / 100ps

module tb_top import csh_pkg::*; ();

	localparam int N_RANDOM = 450;
	localparam int DRAIN_CYCLES = TOTAL_LAT + 10;
	localparam int MAXC = 8388607;
	localparam int MINC = -8388608;

	typedef struct packed {
		logic signed [COORD_W-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
		logic [RAD_W-1:0] r1, r2;
	} pair_t;

	typedef struct packed {
		logic             hit;
		logic [Q_W-1:0]   ratio;
		logic [DIST_W-1:0] dsq;
	} verdict_t;

	// directed row: stimulus, plus a typed expectation where obvious
	typedef struct {
		pair_t    pair;
		bit       typed;
		verdict_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	pair_t drv = '0;
	logic hit;
	logic [Q_W-1:0] t_clamp;
	logic [DIST_W-1:0] dist_squared;

	verdict_t verdict_q[$];
	int n_fail = 0;
	int n_beats_out = 0;
	int n_hits = 0;
	bit long_hold = 1'b0;
	bit sender_done = 1'b0;

	always #5 clk = ~clk;

	capsule_segment_hit_test u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.seg1_start_x(drv.p1x), .seg1_start_y(drv.p1y),
		.seg1_end_x(drv.p2x), .seg1_end_y(drv.p2y),
		.seg2_start_x(drv.q1x), .seg2_start_y(drv.q1y),
		.seg2_end_x(drv.q2x), .seg2_end_y(drv.q2y),
		.radius_one(drv.r1), .radius_two(drv.r2),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .t_clamp(t_clamp), .dist_squared(dist_squared)
	);

	// clamped Q1.16 quotient, truncated toward zero
	function automatic logic [Q_W-1:0] clamp_ratio(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] q;
		if (den <= 0 || num <= 0) return '0;
		if (num >= den) return ONE_Q;
		q = (num <<< QF_W) / den;
		return q[Q_W-1:0];
	endfunction

	// closest points, distance and hit for one segment pair
	function automatic verdict_t capsule_verdict(pair_t p);
		logic signed [63:0] ex, ey, fx, fy, gx, gy, a, b, c, d, e;
		logic signed [127:0] det, sn, tn, rx, ry, dsum, thr;
		logic [Q_W-1:0] s, t;
		verdict_t v;
		ex = 64'(p.p2x) - 64'(p.p1x); ey = 64'(p.p2y) - 64'(p.p1y);
		fx = 64'(p.q2x) - 64'(p.q1x); fy = 64'(p.q2y) - 64'(p.q1y);
		gx = 64'(p.p1x) - 64'(p.q1x); gy = 64'(p.p1y) - 64'(p.q1y);
		a = ex * ex + ey * ey; b = ex * fx + ey * fy; c = fx * fx + fy * fy;
		d = ex * gx + ey * gy; e = fx * gx + fy * gy;
		det = 128'(a) * 128'(c) - 128'(b) * 128'(b);
		if (det == 0) begin
			s = '0;
			t = (b > c) ? clamp_ratio(128'(d), 128'(b)) : clamp_ratio(128'(e), 128'(c));
		end else begin
			sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
			tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
			if (sn < 0) begin
				s = '0; t = clamp_ratio(128'(e), 128'(c));
			end else if (sn > det) begin
				s = ONE_Q; t = clamp_ratio(128'(b + e), 128'(c));
			end else if (tn < 0) begin
				t = '0; s = clamp_ratio(128'(-d), 128'(a));
			end else if (tn > det) begin
				t = ONE_Q; s = clamp_ratio(128'(b - d), 128'(a));
			end else begin
				s = clamp_ratio(sn, det); t = clamp_ratio(tn, det);
			end
		end
		rx = 128'(gx) * 65536 + 128'(s) * 128'(ex) - 128'(t) * 128'(fx);
		ry = 128'(gy) * 65536 + 128'(s) * 128'(ey) - 128'(t) * 128'(fy);
		dsum = rx * rx + ry * ry;
		thr = (128'(p.r1) + 128'(p.r2)) ** 2 <<< 32;
		v.hit = (p.r2 != 0) && (dsum < thr);
		v.ratio = t;
		v.dsq = ((dsum >>> 32) > 128'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
			: dsum[DIST_W+31:32];
		return v;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom);
			1: return {1'b0, {(COORD_W-1){1'b1}}} - COORD_W'($urandom_range(0, 3));
			2: return {1'b1, {(COORD_W-1){1'b0}}} + COORD_W'($urandom_range(0, 3));
			default: return COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int spread;
		spread = ($urandom_range(0, 9) < 8) ? 4096 : 1 << 22;
		p.p1x = rand_coord(spread); p.p1y = rand_coord(spread);
		p.p2x = rand_coord(spread); p.p2y = rand_coord(spread);
		p.q1x = rand_coord(spread); p.q1y = rand_coord(spread);
		p.q2x = rand_coord(spread); p.q2y = rand_coord(spread);
		// degenerate shapes: parallel or zero-length segments
		case ($urandom_range(0, 7))
			0: begin p.q2x = p.q1x; p.q2y = p.q1y; end
			1: begin p.p2x = p.p1x; p.p2y = p.p1y; end
			2: begin p.q2x = p.q1x + (p.p2x - p.p1x); p.q2y = p.q1y + (p.p2y - p.p1y); end
			default: ;
		endcase
		p.r1 = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 8000));
		p.r2 = ($urandom_range(0, 5) == 0) ? '0 : RAD_W'($urandom);
		return p;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
			: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
	endfunction

	function automatic pair_t mk(int p1x, int p1y, int p2x, int p2y, int q1x, int q1y,
			int q2x, int q2y, int r1, int r2);
		pair_t p;
		p.p1x = COORD_W'(p1x); p.p1y = COORD_W'(p1y);
		p.p2x = COORD_W'(p2x); p.p2y = COORD_W'(p2y);
		p.q1x = COORD_W'(q1x); p.q1y = COORD_W'(q1y);
		p.q2x = COORD_W'(q2x); p.q2y = COORD_W'(q2y);
		p.r1 = RAD_W'(r1); p.r2 = RAD_W'(r2);
		return p;
	endfunction

	// offer one beat and hold it until accepted
	task automatic send_pair(pair_t p, bit typed, verdict_t want);
		drv <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		verdict_q.insert(verdict_q.size(), typed ? want : capsule_verdict(p));
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		row_t rows[$];
		row_t r;
		int gap;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero: coincident points, no radius
		r.pair = '0; r.typed = 1'b1; r.want = '{1'b0, '0, '0}; rows.insert(rows.size(), r);
		// coincident points with radius two only: hit at distance zero
		r.pair = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1); r.want = '{1'b1, '0, '0};
		rows.insert(rows.size(), r);
		// zero second radius never hits
		r.pair = mk(0, 0, 0, 0, 0, 0, 0, 0, 65535, 0); r.want = '{1'b0, '0, '0};
		rows.insert(rows.size(), r);
		r.typed = 1'b0;
		r.pair = mk(MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, 65535, 65535);
		rows.insert(rows.size(), r);
		// far apart points: distance squared is 2 * (2^24 - 1)^2
		r.pair = mk(MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, 0, 65535);
		r.typed = 1'b1; r.want = '{1'b0, '0, 52'd562949886312450};
		rows.insert(rows.size(), r);
		r.typed = 1'b0;
		r.pair = mk(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, 1, 1);
		rows.insert(rows.size(), r);
		// parallel overlapping, parallel disjoint, collinear
		r.pair = mk(0, 0, 1000, 0, 200, 100, 800, 100, 100, 100); rows.insert(rows.size(), r);
		r.pair = mk(0, 0, 1000, 0, 2000, 50, 3000, 50, 10, 10); rows.insert(rows.size(), r);
		r.pair = mk(0, 0, 1000, 0, 3000, 0, -500, 0, 1, 1); rows.insert(rows.size(), r);
		// zero-length second segment, zero-length first segment
		r.pair = mk(0, 0, 1000, 0, 500, 300, 500, 300, 200, 200); rows.insert(rows.size(), r);
		r.pair = mk(400, 400, 400, 400, 0, 0, 1000, 0, 200, 250); rows.insert(rows.size(), r);
		// crossing, each clamp branch
		r.pair = mk(0, -500, 0, 500, -500, 0, 500, 0, 1, 1); rows.insert(rows.size(), r);
		r.pair = mk(0, 0, 100, 100, 500, -500, 500, 500, 300, 200); rows.insert(rows.size(), r);
		r.pair = mk(-100, 0, -500, 100, 0, -500, 0, 500, 300, 200); rows.insert(rows.size(), r);
		r.pair = mk(-500, 600, 500, 700, 0, -500, 0, 500, 50, 60); rows.insert(rows.size(), r);
		r.pair = mk(-500, -600, 500, -700, 0, -500, 0, 500, 50, 60); rows.insert(rows.size(), r);
		r.pair = mk(-500, 100, 500, -100, 700, -500, 700, 500, 65535, 65535);
		rows.insert(rows.size(), r);
		r.pair = mk(1, 2, 3, 5, -7, 11, 13, -17, 65535, 1); rows.insert(rows.size(), r);

		foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want);

		for (int i = 0; i < N_RANDOM; i++) begin
			// pause until the pipe is empty once
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				wait (verdict_q.size() == 0);
				@(posedge clk);
			end else begin
				gap = (i > 100 && i < 180) ? 0 : gap_len();
				idle_sender(gap);
			end
			send_pair(rand_pair(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		sender_done = 1'b1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold && n_beats_out > 80) begin
				long_hold = 1'b1;
				out_ready <= 1'b0;
				repeat (3 * TOTAL_LAT) @(posedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && out_valid && out_ready) begin
			n_beats_out++;
			if (hit) n_hits++;
			if (verdict_q.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				n_fail++;
			end else begin
				w = verdict_q.pop_front();
				if (hit !== w.hit) begin
					$display("%0t: hit exp %0d got %0d", $time, w.hit, hit);
					n_fail++;
				end
				if (t_clamp !== w.ratio) begin
					$display("%0t: t_clamp exp %0d got %0d", $time, w.ratio, t_clamp);
					n_fail++;
				end
				if (dist_squared !== w.dsq) begin
					$display("%0t: dist_squared exp %0d got %0d", $time, w.dsq, dist_squared);
					n_fail++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (sender_done);
		wait (verdict_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d result beats, %0d hits, incl. degenerate, clamp and",
			n_beats_out, n_hits);
		$display("extreme coordinate cases, long output hold-off and a full drain pause.");
		if (n_fail == 0 && verdict_q.size() == 0)
			$display("capsule_segment_hit_test verification clean");
		else
			$display("capsule_segment_hit_test verification failed");
		$finish;
	end

	// timeout
	initial begin
		#2_000_000;
		$display("capsule_segment_hit_test verification failed");
		$finish;
	end

endmodule
